// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the stack rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, skipped while reset is held
`define BLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define BLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLS_ASSERT(lbl, prop, msg)
`define BLS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/bls_pkg.sv -----
// types and constants for the bounded lifo stack
package bls_pkg;

  // defaults for the top-level parameters
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths
  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 5;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TOP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BOTTOM = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POS    = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS    = 2'd3;

  typedef struct packed {
    logic        [CMD_W-1:0] cmd;
    logic signed [VAL_W-1:0] push_value;
    logic        [POS_W-1:0] position;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] data;
    logic        [ST_W-1:0]  status;
    logic        [CNT_W-1:0] count;
  } out_rsp_t;

endpackage

// ----- hw/rtl/bounded_lifo_stack.sv -----
// bounded lifo stack with one-port synchronous entry memory
//
//  channel   dir   handshake              payload
//  in_       in    in_valid / in_stall    bls_pkg::in_req_t  in_req
//  out_      out   out_valid / out_stall  bls_pkg::out_rsp_t out_rsp
//  cfg_      in    cfg_valid / cfg_ready  capacity           cfg_capacity
//
// one request per cycle sustained unless the output stalls; a taken request is
// decoded and its memory read registered at the accepting edge into the read
// stage, then its result moves to the output register
// the count and the memory access are settled at the accepting edge, so the next
// request sees them at once and no forwarding is needed
// reset: capacity 10, stack empty; the entry memory is not cleared since only
// entries below the count are ever read
// with the output stalled one more request is taken into the read stage, then
// in_stall rises
`include "assert_macros.svh"

module bounded_lifo_stack #(
  parameter int DEPTH      = bls_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bls_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  bls_pkg::in_req_t         in_req,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output bls_pkg::out_rsp_t        out_rsp,
  // capacity register write
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [bls_pkg::CAP_W-1:0] cfg_capacity
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > bls_pkg::CNT_W) ? CW : bls_pkg::CNT_W;

  // capacity register, writable at any cycle
  logic [bls_pkg::CAP_W-1:0] cap_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bls_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_capacity;
    end
  end

  // pipeline control
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       s1_rd_r;
  logic [bls_pkg::ST_W-1:0]   s1_st_r;
  logic [bls_pkg::CNT_W-1:0]  s1_cnt_r;
  logic                       out_valid_r, out_valid_nxt;
  bls_pkg::out_rsp_t          out_rsp_r;
  logic                       s1_mv;
  logic                       in_acc;

  // read stage drains when the output register is empty or being taken
  assign s1_mv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_mv;
  assign in_acc   = in_valid && !in_stall;

  // request decode against the current count
  logic [CW-1:0]             count_r, count_nxt;
  logic [CMPW-1:0]           cnt_w, cap_w, dep_w, pos_w, cap_eff, addr_w;
  logic [bls_pkg::ST_W-1:0]  st;
  logic                      rd_en, wr_en;
  logic [AW-1:0]             addr;

  assign cnt_w   = CMPW'(count_r);
  assign cap_w   = CMPW'(cap_r);
  assign dep_w   = CMPW'(DEPTH);
  assign pos_w   = CMPW'(in_req.position);
  // capacity above the memory depth saturates
  assign cap_eff = (cap_w > dep_w) ? dep_w : cap_w;
  assign addr    = addr_w[AW-1:0];

  always_comb begin
    st        = bls_pkg::ST_OK;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    addr_w    = '0;
    count_nxt = count_r;
    case (in_req.cmd)
      bls_pkg::CMD_PUSH: begin
        if (cnt_w >= cap_eff) begin
          st = bls_pkg::ST_OVERFLOW;
        end else begin
          wr_en     = 1'b1;
          addr_w    = cnt_w;
          count_nxt = count_r + CW'(1);
        end
      end
      bls_pkg::CMD_POP: begin
        if (count_r == '0) begin
          st = bls_pkg::ST_UNDERFLOW;
        end else begin
          rd_en     = 1'b1;
          addr_w    = cnt_w - CMPW'(1);
          count_nxt = count_r - CW'(1);
        end
      end
      bls_pkg::CMD_TOP: begin
        if (count_r == '0) begin
          st = bls_pkg::ST_UNDERFLOW;
        end else begin
          rd_en  = 1'b1;
          addr_w = cnt_w - CMPW'(1);
        end
      end
      bls_pkg::CMD_BOTTOM: begin
        if (count_r == '0) begin
          st = bls_pkg::ST_UNDERFLOW;
        end else begin
          rd_en = 1'b1;
        end
      end
      bls_pkg::CMD_POS: begin
        // valid positions run from one up to the count
        if (pos_w == '0 || pos_w > cnt_w) begin
          st = bls_pkg::ST_BADPOS;
        end else begin
          rd_en  = 1'b1;
          addr_w = pos_w - CMPW'(1);
        end
      end
      default: begin
        // unknown command: nothing changes, status ok
        st = bls_pkg::ST_OK;
      end
    endcase
  end

  // entry memory, one access per cycle, registered read
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] mem_q_r;
  logic [63:0]           wr64;

  // narrow storage keeps the low bits, wide storage zero-fills above the field
  assign wr64 = {32'b0, in_req.push_value};

  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      mem[addr] <= wr64[DATA_WIDTH-1:0];
    end
    if (in_acc && rd_en) begin
      mem_q_r <= mem[addr];
    end
  end

  // count and stage valids
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_mv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_mv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r <= count_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // read stage payload
  logic [CMPW-1:0] cnt_nxt_w;

  assign cnt_nxt_w = CMPW'(count_nxt);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rd_r  <= rd_en;
      s1_st_r  <= st;
      s1_cnt_r <= cnt_nxt_w[bls_pkg::CNT_W-1:0];
    end
  end

  // read data sign-extended from the storage width
  logic [63:0] rd64;

  assign rd64 = 64'($signed(mem_q_r));

  always_ff @(posedge clk) begin
    if (s1_mv) begin
      out_rsp_r.data   <= s1_rd_r ? rd64[31:0] : '0;
      out_rsp_r.status <= s1_st_r;
      out_rsp_r.count  <= s1_cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `BLS_ASSERT(a_count_bound, (count_r <= CW'(DEPTH)), "count above depth")
  `BLS_ASSERT(a_stall_full, (in_stall |-> (s1_valid_r && out_valid_r)), "stall with room")
  `BLS_ASSERT(a_push_inc, ((in_acc && in_req.cmd == bls_pkg::CMD_PUSH && st == bls_pkg::ST_OK) |=> (count_r == $past(count_r) + CW'(1))), "push did not grow count")
  `BLS_ASSERT(a_pop_dec, ((in_acc && in_req.cmd == bls_pkg::CMD_POP && st == bls_pkg::ST_OK) |=> (count_r == $past(count_r) - CW'(1))), "pop did not shrink count")

endmodule

// ----- test/bls_stack_checker.sv -----
// checker for the bounded lifo stack: mirrors the stack and scores every result
module bls_stack_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  bls_pkg::in_req_t          in_req,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  bls_pkg::out_rsp_t         out_rsp,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [bls_pkg::CAP_W-1:0] cfg_capacity,
  output int                        mismatches,
  output int                        pending
);

  localparam int STACK_DEPTH = bls_pkg::DEPTH_DEF;

  logic signed [bls_pkg::VAL_W-1:0] stack_mem [STACK_DEPTH];
  logic [bls_pkg::CNT_W-1:0]        fill;
  logic [bls_pkg::CAP_W-1:0]        cap_reg;
  bls_pkg::out_rsp_t                rsp_due [$];

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // one request against the mirrored stack
  task automatic apply_stack_op(input bls_pkg::in_req_t req, output bls_pkg::out_rsp_t rsp);
    int lim;
    lim = (int'(cap_reg) > STACK_DEPTH) ? STACK_DEPTH : int'(cap_reg);
    rsp = '0;
    rsp.status = bls_pkg::ST_OK;
    case (req.cmd)
      bls_pkg::CMD_PUSH: begin
        if (int'(fill) >= lim) begin
          rsp.status = bls_pkg::ST_OVERFLOW;
        end else begin
          stack_mem[fill] = req.push_value;
          fill = fill + 1'b1;
        end
      end
      bls_pkg::CMD_POP: begin
        if (fill == 0) begin
          rsp.status = bls_pkg::ST_UNDERFLOW;
        end else begin
          fill = fill - 1'b1;
          rsp.data = stack_mem[fill];
        end
      end
      bls_pkg::CMD_TOP: begin
        if (fill == 0) rsp.status = bls_pkg::ST_UNDERFLOW;
        else rsp.data = stack_mem[fill - 1'b1];
      end
      bls_pkg::CMD_BOTTOM: begin
        if (fill == 0) rsp.status = bls_pkg::ST_UNDERFLOW;
        else rsp.data = stack_mem[0];
      end
      bls_pkg::CMD_POS: begin
        if (req.position == 0 || req.position > fill) rsp.status = bls_pkg::ST_BADPOS;
        else rsp.data = stack_mem[req.position - 1'b1];
      end
      default: begin
      end
    endcase
    rsp.count = fill;
  endtask

  always @(posedge clk) begin : watch
    bls_pkg::out_rsp_t want;
    bls_pkg::out_rsp_t got;
    if (!rst_n) begin
      fill       = '0;
      cap_reg    = bls_pkg::CAP_RESET;
      mismatches = 0;
      rsp_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = cfg_capacity;
      if (out_valid && !out_stall) begin
        got = out_rsp;
        if (rsp_due.size() == 0) begin
          flag_mismatch("result with none due, data", got.data, 0);
        end else begin
          want = rsp_due.pop_front();
          if (got.data !== want.data) flag_mismatch("data", got.data, want.data);
          if (got.status !== want.status) flag_mismatch("status", got.status, want.status);
          if (got.count !== want.count) flag_mismatch("count", got.count, want.count);
        end
      end
      if (in_valid && !in_stall) begin
        apply_stack_op(in_req, want);
        rsp_due.push_back(want);
      end
    end
    pending = rsp_due.size();
  end

endmodule

// ----- test/bounded_lifo_stack_tb.sv -----
// testbench top for the bounded lifo stack: stimulus, idling and verdict
module bounded_lifo_stack_tb;

  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake at all
  localparam int LONG_HOLD   = 60;    // receiver hold-off that backs up the block
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 155;
  localparam int HOLD_PHASE  = 7;

  localparam int CMD_BITS = bls_pkg::CMD_W;
  localparam int VAL_BITS = bls_pkg::VAL_W;
  localparam int POS_BITS = bls_pkg::POS_W;
  localparam int CAP_BITS = bls_pkg::CAP_W;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  bls_pkg::in_req_t     in_req;
  logic                 out_valid;
  logic                 out_stall;
  bls_pkg::out_rsp_t    out_rsp;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CAP_BITS-1:0]  cfg_capacity;

  int mismatches;
  int pending;

  // shared knobs between the request side and the result side
  bit idle_on   = 1'b1;
  bit long_hold = 1'b0;

  bounded_lifo_stack i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req       (in_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rsp      (out_rsp),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_capacity (cfg_capacity)
  );

  bls_stack_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req       (in_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rsp      (out_rsp),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_capacity (cfg_capacity),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bls_pkg::in_req_t make_req(input logic [CMD_BITS-1:0] c,
                                                input logic [VAL_BITS-1:0] v,
                                                input logic [POS_BITS-1:0] p);
    bls_pkg::in_req_t r;
    r.cmd        = c;
    r.push_value = v;
    r.position   = p;
    return r;
  endfunction

  // mostly full-range values, now and then one of the corner values
  function automatic logic [VAL_BITS-1:0] rand_val();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // push share per phase steers the count toward full or empty
  function automatic bls_pkg::in_req_t rand_req(input int push_pct);
    bls_pkg::in_req_t r;
    int               pick;
    r.push_value = rand_val();
    // positions mostly around the stack range, sometimes any 5-bit value
    r.position = ($urandom_range(0, 7) == 0) ? POS_BITS'($urandom_range(0, 31))
                                             : POS_BITS'($urandom_range(0, 17));
    pick = $urandom_range(0, 99);
    if (pick < push_pct) begin
      r.cmd = bls_pkg::CMD_PUSH;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 8)       r.cmd = bls_pkg::CMD_POP;
      else if (pick < 11) r.cmd = bls_pkg::CMD_TOP;
      else if (pick < 14) r.cmd = bls_pkg::CMD_BOTTOM;
      else if (pick < 19) r.cmd = bls_pkg::CMD_POS;
      else r.cmd = bls_pkg::CMD_POS + CMD_BITS'($urandom_range(1, 3));  // unused codes
    end
    return r;
  endfunction

  // capacity per phase: extremes, saturation above depth, lowering below the count
  function automatic logic [CAP_BITS-1:0] phase_cap(input int k);
    case (k)
      0:  return bls_pkg::CAP_RESET;
      1:  return 5'd16;
      2:  return 5'd3;   // below the count left by the fill phase
      3:  return 5'd0;   // every push overflows
      4:  return 5'd31;  // saturates at depth
      5:  return 5'd1;
      6:  return 5'd17;
      7:  return 5'd16;
      8:  return CAP_BITS'($urandom_range(1, 16));
      9:  return 5'd2;
      10: return CAP_BITS'($urandom_range(0, 31));
      default: return 5'd16;
    endcase
  endfunction

  function automatic int phase_push(input int k);
    case (k)
      1, 7:    return 75;
      2:       return 30;
      4, 6:    return 65;
      3:       return 40;
      9:       return 45;
      default: return 55;
    endcase
  endfunction

  // offer one request, with an optional idle burst in front, until it is taken
  task automatic offer_req(input bls_pkg::in_req_t req);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);  // two-stage pipe, a little slack on top
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] v);
    cfg_valid    <= 1'b1;
    cfg_capacity <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result side: short random stall bursts, or one long hold-off on request
  initial begin : result_sink
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        // hold off long enough that the block fills and raises in_stall
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: ends the run when no handshake happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int k;
    int n;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_req       <= '0;
    cfg_valid    <= 1'b0;
    cfg_capacity <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty stack at reset capacity: every read reports underflow or bad position
    offer_req(make_req(bls_pkg::CMD_POP,    32'h0, 5'd0));
    offer_req(make_req(bls_pkg::CMD_TOP,    32'h0, 5'd0));
    offer_req(make_req(bls_pkg::CMD_BOTTOM, 32'h0, 5'd0));
    offer_req(make_req(bls_pkg::CMD_POS,    32'h0, 5'd0));
    // unused command codes change nothing
    offer_req(make_req(bls_pkg::CMD_POS + 3'd1, 32'hffff_ffff, 5'd31));
    offer_req(make_req(bls_pkg::CMD_POS + 3'd2, 32'h0, 5'd1));
    offer_req(make_req(bls_pkg::CMD_POS + 3'd3, 32'h5555_aaaa, 5'd16));
    // extreme values
    offer_req(make_req(bls_pkg::CMD_PUSH, 32'h7fff_ffff, 5'd0));
    offer_req(make_req(bls_pkg::CMD_PUSH, 32'h8000_0000, 5'd0));
    offer_req(make_req(bls_pkg::CMD_PUSH, 32'hffff_ffff, 5'd0));
    offer_req(make_req(bls_pkg::CMD_PUSH, 32'h0000_0000, 5'd0));
    offer_req(make_req(bls_pkg::CMD_TOP,    32'h0, 5'd0));
    offer_req(make_req(bls_pkg::CMD_BOTTOM, 32'h0, 5'd0));
    // positions: first, last, one past the count, far out, depth
    offer_req(make_req(bls_pkg::CMD_POS, 32'h0, 5'd1));
    offer_req(make_req(bls_pkg::CMD_POS, 32'h0, 5'd4));
    offer_req(make_req(bls_pkg::CMD_POS, 32'h0, 5'd5));
    offer_req(make_req(bls_pkg::CMD_POS, 32'h0, 5'd31));
    offer_req(make_req(bls_pkg::CMD_POS, 32'h0, 5'd16));
    repeat (4) offer_req(make_req(bls_pkg::CMD_POP, 32'h0, 5'd0));
    offer_req(make_req(bls_pkg::CMD_POP, 32'h0, 5'd0));
    drain();
    // smallest nonzero capacity: second push overflows
    write_capacity(5'd1);
    offer_req(make_req(bls_pkg::CMD_PUSH, 32'ha5a5_5a5a, 5'd0));
    offer_req(make_req(bls_pkg::CMD_PUSH, 32'h1234_5678, 5'd0));
    offer_req(make_req(bls_pkg::CMD_POP,  32'h0, 5'd0));
    drain();

    // random phases, one capacity each, drained before the next write
    for (k = 0; k < PHASES; k++) begin
      if (k == PHASES - 1) idle_on = 1'b0;  // no idling in the last part
      write_capacity(phase_cap(k));
      if (k == HOLD_PHASE) long_hold = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) offer_req(rand_req(phase_push(k)));
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
